// ===== sv/heartbeat_tx_rx_timeout_monitor_unit_assert.svh =====
// Assertion macros for the heartbeat monitor checker.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef HEARTBEAT_TX_RX_TIMEOUT_MONITOR_UNIT_ASSERT_SVH
`define HEARTBEAT_TX_RX_TIMEOUT_MONITOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HBM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("hbmon assertion failed");

// next-cycle implication, disabled during reset
`define HBM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("hbmon assertion failed");

`endif

// ===== sv/hbmon_pkg.sv =====
// Shared types and constants for the heartbeat monitor.
// No dependencies; imported by every module of the block.
`default_nettype none

package hbmon_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] TX_PERIOD_RST = 8'd5;
    localparam logic [BYTE_W-1:0] ALIVE_MAX_RST = 8'd15;
    localparam logic [BYTE_W-1:0] MAX_MISS_RST  = 8'd3;
    localparam logic [BYTE_W-1:0] NODE_ID_RST   = 8'd0;
    localparam logic [BYTE_W-1:0] MISS_SAT      = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TX_PERIOD = 2'd0,
        CFG_ALIVE_MAX = 2'd1,
        CFG_MAX_MISS  = 2'd2,
        CFG_NODE_ID   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_FAILED = 2'd1,
        EV_PASSED = 2'd2
    } t_event;

    typedef struct packed {
        logic [BYTE_W-1:0] sys_mode;
        logic [BYTE_W-1:0] alive_seen_a;
        logic [BYTE_W-1:0] alive_seen_b;
        logic              rx_ind_a;
        logic              rx_ind_b;
    } t_in_item;

    typedef struct packed {
        logic              send_valid;
        logic [BYTE_W-1:0] tx_alive;
        logic [BYTE_W-1:0] tx_node_id;
        logic [BYTE_W-1:0] tx_sys_mode;
        logic              status_a;
        logic              status_b;
        logic [1:0]        event_a;
        logic [1:0]        event_b;
    } t_out_item;

    // heartbeat side result of one tick
    typedef struct packed {
        logic              boundary;
        logic [BYTE_W-1:0] alive;
        logic [BYTE_W-1:0] node_id;
        logic [BYTE_W-1:0] sys_mode;
    } t_tx_res;

    // partner supervision result of one tick
    typedef struct packed {
        logic   status;
        t_event evt;
    } t_partner_res;

endpackage

`default_nettype wire

// ===== sv/hbmon_tx.sv =====
// Heartbeat transmit path: tick divider and own alive counter.
// Depends on hbmon_pkg.
`default_nettype none

module hbmon_tx
    import hbmon_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_sys_mode,
    input  wire logic [BYTE_W-1:0] i_tx_period,
    input  wire logic [BYTE_W-1:0] i_alive_max,
    input  wire logic [BYTE_W-1:0] i_node_id,
    output t_tx_res                o_res
);

    logic [BYTE_W-1:0] r_tick;
    logic [BYTE_W-1:0] r_alive;
    logic [BYTE_W-1:0] n_tick;
    logic [BYTE_W-1:0] n_alive;
    logic [BYTE_W:0]   tick_inc;
    logic [BYTE_W-1:0] alive_inc;
    logic              boundary;

    // boundary when the incremented tick reaches the period
    always_comb begin
        tick_inc  = {1'b0, r_tick} + {{BYTE_W{1'b0}}, 1'b1};
        boundary  = (tick_inc >= {1'b0, i_tx_period});
        alive_inc = r_alive + {{(BYTE_W-1){1'b0}}, 1'b1};
        n_tick    = boundary ? '0 : tick_inc[BYTE_W-1:0];
        if (boundary) begin
            n_alive = (alive_inc > i_alive_max) ? '0 : alive_inc;
        end else begin
            n_alive = r_alive;
        end
    end

    // heartbeat fields read as zero on non-boundary ticks
    always_comb begin
        o_res.boundary = boundary;
        o_res.alive    = boundary ? r_alive    : '0;
        o_res.node_id  = boundary ? i_node_id  : '0;
        o_res.sys_mode = boundary ? i_sys_mode : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_alive <= '0;
        end else if (i_step) begin
            r_tick  <= n_tick;
            r_alive <= n_alive;
        end
    end

endmodule

`default_nettype wire

// ===== sv/hbmon_partner.sv =====
// Reception supervision of one partner node: miss count and timeout status.
// Depends on hbmon_pkg.
`default_nettype none

module hbmon_partner
    import hbmon_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic              i_boundary,
    input  wire logic [BYTE_W-1:0] i_alive_seen,
    input  wire logic              i_rx_ind,
    input  wire logic [BYTE_W-1:0] i_max_miss,
    output t_partner_res           o_res
);

    logic [BYTE_W-1:0] r_miss;
    logic [BYTE_W-1:0] r_last;
    logic              r_heard;
    logic              r_timed_out;
    logic [BYTE_W-1:0] n_miss;
    logic [BYTE_W-1:0] n_last;
    logic              n_heard;
    logic              n_timed_out;
    logic [BYTE_W-1:0] miss_inc;
    logic              heard_now;
    logic              heard_eff;
    t_event            evt;

    always_comb begin
        // indication is latched before the tick is evaluated
        heard_now   = r_heard | i_rx_ind;
        heard_eff   = heard_now | (i_alive_seen != r_last);
        miss_inc    = (r_miss == MISS_SAT) ? r_miss
                                           : r_miss + {{(BYTE_W-1){1'b0}}, 1'b1};
        n_miss      = r_miss;
        n_last      = r_last;
        n_heard     = heard_now;
        n_timed_out = r_timed_out;
        evt         = EV_NONE;
        if (i_boundary) begin
            n_last  = i_alive_seen;
            n_heard = 1'b0;
            if (heard_eff) begin
                // partner alive: clear misses, recover from timeout
                n_miss      = '0;
                n_timed_out = 1'b0;
                if (r_timed_out) begin
                    evt = EV_PASSED;
                end
            end else begin
                n_miss = miss_inc;
                if ((miss_inc >= i_max_miss) && !r_timed_out) begin
                    n_timed_out = 1'b1;
                    evt         = EV_FAILED;
                end
            end
        end
    end

    assign o_res.status = n_timed_out;
    assign o_res.evt    = evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss      <= '0;
            r_last      <= '0;
            r_heard     <= 1'b0;
            r_timed_out <= 1'b1;
        end else if (i_step) begin
            r_miss      <= n_miss;
            r_last      <= n_last;
            r_heard     <= n_heard;
            r_timed_out <= n_timed_out;
        end
    end

endmodule

`default_nettype wire

// ===== sv/heartbeat_tx_rx_timeout_monitor_unit.sv =====
// Channel    | Dir | Handshake                 | Payload
// -----------+-----+---------------------------+-----------------------
// tick in    | in  | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
// result out | out | o_out_valid / i_out_stall | o_out_data (t_out_item)
// config     | in  | i_cfg_we                  | i_cfg_idx, i_cfg_wdata
//
// One request per cycle sustained while the result side does not stall; a
// request passes the input register, one pass of tick/alive and partner logic, then the result register.
// Reset (synchronous, active low) clears both stages, restores the config
// defaults, and puts both partners in timeout. A stalled result holds the
// result register; the input register then holds one request, then stalls.
// Depends on hbmon_pkg, hbmon_tx and hbmon_partner.
`default_nettype none

module heartbeat_tx_rx_timeout_monitor_unit
    import hbmon_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTE_W-1:0]    i_cfg_wdata
);

    logic [BYTE_W-1:0] r_tx_period;
    logic [BYTE_W-1:0] r_alive_max;
    logic [BYTE_W-1:0] r_max_miss;
    logic [BYTE_W-1:0] r_node_id;

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    t_out_item n_out;

    logic         out_ready;
    logic         step;
    logic         in_acc;
    t_tx_res      tx_res;
    t_partner_res res_a;
    t_partner_res res_b;

    // handshake
    assign out_ready   = !r_out_vld || !i_out_stall;
    assign step        = r_in_vld && out_ready;
    assign o_in_stall  = r_in_vld && !out_ready;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_period <= TX_PERIOD_RST;
            r_alive_max <= ALIVE_MAX_RST;
            r_max_miss  <= MAX_MISS_RST;
            r_node_id   <= NODE_ID_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TX_PERIOD: r_tx_period <= i_cfg_wdata;
                CFG_ALIVE_MAX: r_alive_max <= i_cfg_wdata;
                CFG_MAX_MISS:  r_max_miss  <= i_cfg_wdata;
                CFG_NODE_ID:   r_node_id   <= i_cfg_wdata;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!r_in_vld || step) begin
            r_in_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    hbmon_tx u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_sys_mode  (r_in.sys_mode),
        .i_tx_period (r_tx_period),
        .i_alive_max (r_alive_max),
        .i_node_id   (r_node_id),
        .o_res       (tx_res)
    );

    hbmon_partner u_partner_a (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_boundary   (tx_res.boundary),
        .i_alive_seen (r_in.alive_seen_a),
        .i_rx_ind     (r_in.rx_ind_a),
        .i_max_miss   (r_max_miss),
        .o_res        (res_a)
    );

    hbmon_partner u_partner_b (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_boundary   (tx_res.boundary),
        .i_alive_seen (r_in.alive_seen_b),
        .i_rx_ind     (r_in.rx_ind_b),
        .i_max_miss   (r_max_miss),
        .o_res        (res_b)
    );

    // result assembly
    always_comb begin
        n_out.send_valid  = tx_res.boundary;
        n_out.tx_alive    = tx_res.alive;
        n_out.tx_node_id  = tx_res.node_id;
        n_out.tx_sys_mode = tx_res.sys_mode;
        n_out.status_a    = res_a.status;
        n_out.status_b    = res_b.status;
        n_out.event_a     = res_a.evt;
        n_out.event_b     = res_b.evt;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ready) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== sv/hbmon_chk.sv =====
// Port-level checker for the heartbeat monitor, bound to the top level.
// Depends on hbmon_pkg and heartbeat_tx_rx_timeout_monitor_unit_assert.svh.
`default_nettype none

`include "heartbeat_tx_rx_timeout_monitor_unit_assert.svh"

module hbmon_chk
    import hbmon_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    // no heartbeat means empty heartbeat fields
    `HBM_ASSERT_IMP(a_idle_tx_zero, o_out_valid && !o_out_data.send_valid, o_out_data.tx_alive == '0 && o_out_data.tx_node_id == '0 && o_out_data.tx_sys_mode == '0)

    // a failed event leaves the partner in timeout, a passed one leaves it ok
    `HBM_ASSERT_IMP(a_evt_status_a, o_out_valid && o_out_data.event_a != EV_NONE, o_out_data.status_a == (o_out_data.event_a == EV_FAILED))
    `HBM_ASSERT_IMP(a_evt_status_b, o_out_valid && o_out_data.event_b != EV_NONE, o_out_data.status_b == (o_out_data.event_b == EV_FAILED))

    // stalled result holds
    `HBM_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind heartbeat_tx_rx_timeout_monitor_unit hbmon_chk u_hbmon_chk (.*);

`default_nettype wire

// ===== bench/heartbeat_tx_rx_timeout_monitor_unit_tb.sv =====
// Self-checking bench for the heartbeat transmitter / partner timeout monitor.
// A scoreboard class predicts each tick's result; tasks drive ticks and config.
// Depends on hbmon_pkg and heartbeat_tx_rx_timeout_monitor_unit.
`timescale 1ns / 1ps

module heartbeat_tx_rx_timeout_monitor_unit_tb;
    import hbmon_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} t_stall_mode;

    // Predicts the monitor tick by tick and checks its results in order
    class hb_scoreboard;
        logic [BYTE_W-1:0] period, alive_max, miss_limit, node_id;
        logic [BYTE_W-1:0] ticks, own_alive, miss_a, miss_b, last_a, last_b;
        bit heard_a, heard_b, tout_a, tout_b;
        t_out_item tick_results_q[$];
        int unsigned n_ticks, n_beats, n_failed, n_passed, n_errors;

        function new();
            period     = TX_PERIOD_RST;
            alive_max  = ALIVE_MAX_RST;
            miss_limit = MAX_MISS_RST;
            node_id    = NODE_ID_RST;
            ticks      = '0;
            own_alive  = '0;
            miss_a     = '0;
            miss_b     = '0;
            last_a     = '0;
            last_b     = '0;
            heard_a    = 1'b0;
            heard_b    = 1'b0;
            tout_a     = 1'b1;
            tout_b     = 1'b1;
            n_ticks    = 0;
            n_beats    = 0;
            n_failed   = 0;
            n_passed   = 0;
            n_errors   = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [BYTE_W-1:0] v);
            case (idx)
                CFG_TX_PERIOD: period = v;
                CFG_ALIVE_MAX: alive_max = v;
                CFG_MAX_MISS:  miss_limit = v;
                CFG_NODE_ID:   node_id = v;
                default: ;
            endcase
        endfunction

        // One partner's supervision on a period boundary
        function t_event judge_partner(input logic [BYTE_W-1:0] seen,
                                       inout logic [BYTE_W-1:0] last, inout bit heard,
                                       inout logic [BYTE_W-1:0] miss, inout bit tout);
            t_event ev;
            ev = EV_NONE;
            if (seen != last) begin
                heard = 1'b1;
                last  = seen;
            end
            if (heard) begin
                miss  = '0;
                heard = 1'b0;
                if (tout) begin
                    tout = 1'b0;
                    ev   = EV_PASSED;
                end
            end else begin
                if (miss < MISS_SAT)
                    miss = miss + 8'd1;
                if (miss >= miss_limit && !tout) begin
                    tout = 1'b1;
                    ev   = EV_FAILED;
                end
            end
            return ev;
        endfunction

        // Accepted tick: advance the predicted state and queue its result
        function void accept_tick(t_in_item it);
            t_out_item r;
            logic [BYTE_W:0] nxt;
            r = '0;
            if (it.rx_ind_a) heard_a = 1'b1;
            if (it.rx_ind_b) heard_b = 1'b1;
            nxt = {1'b0, ticks} + 9'd1;
            if (nxt >= {1'b0, period}) begin
                r.send_valid  = 1'b1;
                r.tx_alive    = own_alive;
                r.tx_node_id  = node_id;
                r.tx_sys_mode = it.sys_mode;
                own_alive = own_alive + 8'd1;
                if (own_alive > alive_max)
                    own_alive = '0;
                ticks = '0;
                r.event_a = judge_partner(it.alive_seen_a, last_a, heard_a, miss_a, tout_a);
                r.event_b = judge_partner(it.alive_seen_b, last_b, heard_b, miss_b, tout_b);
                n_beats++;
                n_failed += int'(r.event_a == EV_FAILED) + int'(r.event_b == EV_FAILED);
                n_passed += int'(r.event_a == EV_PASSED) + int'(r.event_b == EV_PASSED);
            end else begin
                ticks = nxt[BYTE_W-1:0];
            end
            r.status_a = tout_a;
            r.status_b = tout_b;
            tick_results_q.push_back(r);
            n_ticks++;
        endfunction

        function void cmp_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (tick_results_q.size() == 0) begin
                $display("%0t: result with no tick pending: expected none, actual %h",
                         $time, got);
                n_errors++;
                return;
            end
            want = tick_results_q.pop_front();
            cmp_field("send_valid", 8'(want.send_valid), 8'(got.send_valid));
            cmp_field("tx_alive", want.tx_alive, got.tx_alive);
            cmp_field("tx_node_id", want.tx_node_id, got.tx_node_id);
            cmp_field("tx_sys_mode", want.tx_sys_mode, got.tx_sys_mode);
            cmp_field("status_a", 8'(want.status_a), 8'(got.status_a));
            cmp_field("status_b", 8'(want.status_b), 8'(got.status_b));
            cmp_field("event_a", 8'(want.event_a), 8'(got.event_a));
            cmp_field("event_b", 8'(want.event_b), 8'(got.event_b));
        endfunction

        function int pending();
            return tick_results_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0]    i_cfg_wdata;

    hb_scoreboard sb;
    int unsigned  cycle_count = 0;
    int unsigned  n_settings = 0;

    // partner traffic generator state
    logic [BYTE_W-1:0] pa_val = '0, pb_val = '0;
    bit                pa_live = 1'b1, pb_live = 1'b1;

    heartbeat_tx_rx_timeout_monitor_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Handshake monitor: both channels sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.accept_tick(i_in_data);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_data);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result-side stall pattern, switching mode every segment
    initial begin
        t_stall_mode mode;
        int seg;
        int run;
        i_out_stall = 1'b0;
        run = 0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            seg  = $urandom_range(20, 200);
            repeat (seg) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: begin
                        if (run > 0) begin
                            run--;
                            i_out_stall <= 1'b1;
                        end else if ($urandom_range(0, 19) == 0) begin
                            run = $urandom_range(3, 15);
                            i_out_stall <= 1'b1;
                        end else begin
                            i_out_stall <= 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    // Next tick: live partners bump their counters now and then, silent ones
    // hold; a small share is noise with every field random
    function automatic t_in_item make_tick(bit hush);
        t_in_item it;
        it.sys_mode = 8'($urandom_range(0, 255));
        if (!hush && $urandom_range(0, 19) == 0) begin
            it.alive_seen_a = 8'($urandom_range(0, 255));
            it.alive_seen_b = 8'($urandom_range(0, 255));
            it.rx_ind_a     = 1'($urandom_range(0, 1));
            it.rx_ind_b     = 1'($urandom_range(0, 1));
            pa_val = it.alive_seen_a;
            pb_val = it.alive_seen_b;
            return it;
        end
        it.rx_ind_a = 1'b0;
        it.rx_ind_b = 1'b0;
        if (!hush) begin
            if ($urandom_range(0, 39) == 0) pa_live = !pa_live;
            if ($urandom_range(0, 39) == 0) pb_live = !pb_live;
            if (pa_live) begin
                if ($urandom_range(0, 2) == 0) pa_val = pa_val + 8'd1;
                it.rx_ind_a = ($urandom_range(0, 7) == 0);
            end
            if (pb_live) begin
                if ($urandom_range(0, 2) == 0) pb_val = pb_val + 8'd1;
                it.rx_ind_b = ($urandom_range(0, 7) == 0);
            end
        end
        it.alive_seen_a = pa_val;
        it.alive_seen_b = pb_val;
        return it;
    endfunction

    // Present one request; returns at the falling edge after acceptance
    task automatic send_tick(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic [7:0] vs, input logic [7:0] a,
                               input logic [7:0] b, input bit ia, input bit ib);
        t_in_item it;
        it.sys_mode     = vs;
        it.alive_seen_a = a;
        it.alive_seen_b = b;
        it.rx_ind_a     = ia;
        it.rx_ind_b     = ib;
        send_tick(it);
    endtask

    // Wait until every predicted result has come back, then let the pipe settle
    task automatic wait_idle();
        while (sb.pending() > 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic end_stream();
        i_in_valid <= 1'b0;
        wait_idle();
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [BYTE_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] p, input logic [7:0] amax,
                              input logic [7:0] mm, input logic [7:0] node);
        write_reg(CFG_TX_PERIOD, p);
        write_reg(CFG_ALIVE_MAX, amax);
        write_reg(CFG_MAX_MISS, mm);
        write_reg(CFG_NODE_ID, node);
        n_settings++;
    endtask

    // Stream of generated ticks in bursts, with gaps and occasional full drains
    task automatic run_items(input int n, input bit hush, input bit gaps_on);
        int burst_left;
        int gap;
        t_in_item it;
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) begin
            it = make_tick(hush);
            send_tick(it);
            burst_left--;
            if (gaps_on && burst_left <= 0 && i != n - 1) begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 6);
                if ($urandom_range(0, 39) == 0) begin
                    i_in_valid <= 1'b0;
                    wait_idle();
                end else if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
        end_stream();
    endtask

    initial begin
        logic [7:0] p, amax, mm;
        sb = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: indications on off-boundary ticks are held until the check
        send_fields(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        send_fields(8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0);
        send_fields(8'hAA, 8'hFF, 8'h00, 1'b0, 1'b0);
        send_fields(8'h55, 8'hFF, 8'h00, 1'b0, 1'b1);
        send_fields(8'h01, 8'hFF, 8'h00, 1'b0, 1'b0);
        repeat (5) send_fields(8'h80, 8'hFF, 8'h00, 1'b0, 1'b0);
        repeat (4) send_fields(8'h7F, 8'hFF, 8'h00, 1'b0, 1'b0);
        send_fields(8'hFE, 8'hFF, 8'h00, 1'b1, 1'b0);
        end_stream();

        // Every tick a boundary: miss, timeout, recovery by change and by indication
        set_config(8'd1, 8'd255, 8'd2, 8'hC3);
        send_fields(8'h11, 8'hFF, 8'h00, 1'b0, 1'b0);
        send_fields(8'h22, 8'hFF, 8'h00, 1'b0, 1'b0);
        send_fields(8'h33, 8'hFF, 8'h00, 1'b0, 1'b0);
        send_fields(8'h44, 8'h80, 8'h00, 1'b0, 1'b0);
        send_fields(8'h88, 8'h80, 8'h01, 1'b0, 1'b1);
        send_fields(8'hFF, 8'h80, 8'h01, 1'b1, 1'b1);
        send_fields(8'h00, 8'h00, 8'hFF, 1'b0, 1'b0);
        send_fields(8'h5A, 8'h00, 8'hFF, 1'b0, 1'b0);
        end_stream();

        // Zero period and zero miss limit, smallest alive range, largest node id
        set_config(8'd0, 8'd0, 8'd0, 8'hFF);
        run_items(150, 1'b0, 1'b1);

        // Silent partners: miss count saturates, alive counter wraps at 255
        set_config(8'd1, 8'd255, 8'd255, 8'h00);
        run_items(320, 1'b1, 1'b1);
        run_items(30, 1'b0, 1'b0);

        // Longest period; leaves the tick count part way into a period
        set_config(8'd255, 8'd255, 8'd1, 8'h5A);
        run_items(300, 1'b0, 1'b1);

        // Lowered period and alive maximum take effect on the next boundary
        write_reg(CFG_TX_PERIOD, 8'd4);
        write_reg(CFG_ALIVE_MAX, 8'd10);
        n_settings++;
        run_items(60, 1'b0, 1'b1);

        // Random settings, mostly short periods and low miss limits
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 9))
                0:       p = 8'd0;
                1, 2:    p = 8'($urandom_range(7, 40));
                default: p = 8'($urandom_range(1, 6));
            endcase
            amax = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                               : 8'($urandom_range(0, 255));
            mm = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 5));
            set_config(p, amax, mm, 8'($urandom_range(0, 255)));
            run_items(150, 1'b0, ($urandom_range(0, 3) != 0));
        end

        $display("Covered %0d ticks under %0d register settings: %0d heartbeats, %0d timeouts,",
                 sb.n_ticks, n_settings, sb.n_beats, sb.n_failed);
        $display("%0d recoveries; %0d mismatches, %0d results still owed.",
                 sb.n_passed, sb.n_errors, sb.pending());
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/hbmon_pkg.sv
sv/hbmon_tx.sv
sv/hbmon_partner.sv
sv/heartbeat_tx_rx_timeout_monitor_unit.sv
sv/hbmon_chk.sv
bench/heartbeat_tx_rx_timeout_monitor_unit_tb.sv
